// File: hw/rtl/hflgr_pkg.sv
// Package for the hex font loader and glyph renderer.
// Holds the item structs, controller command/status structs, constants and the hex digit decoder.
// No dependencies.
`default_nettype none

package hflgr_pkg;

  localparam int GLYPH_COUNT = 65536;
  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
  localparam int ROW_W       = $clog2(GLYPH_ROWS);
  localparam int ROW_BITS_W  = 8 * GLYPH_ROWS;
  localparam int DIM_W       = 13;
  localparam int COORD_W     = 12;
  localparam int PIX_W       = 24;
  localparam int CFG_IDX_W   = 1;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic        command;
    logic [7:0]  font_byte;
    logic [8:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] codepoint;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic [7:0]       row_bits;
    logic [7:0]       write_mask;
    logic [31:0]      row_fg_color;
    logic [31:0]      row_bg_color;
    logic             last_row;
  } out_item_t;

  typedef struct packed {
    logic clear_wr;
    logic load_byte;
    logic draw_start;
    logic draw_setup;
    logic row_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic row_last;
  } dp_status_t;

  // Characters outside 0-9, a-f and A-F decode as zero.
  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [3:0] d;
    d = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      d = b[3:0];
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      d = b[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hflgr_ctrl.sv
// Controller state machine for the hex font loader and glyph renderer.
// Depends on hflgr_pkg for the command and status structs.
`default_nettype none

module hflgr_ctrl
  import hflgr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_command,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.clear_wr   = (state_r == ST_CLEAR);
    cmd.load_byte  = accept && (in_command == CMD_LOAD);
    cmd.draw_start = accept && (in_command == CMD_DRAW);
    cmd.draw_setup = (state_r == ST_SETUP);
    cmd.row_next   = (state_r == ST_EMIT) && out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.draw_start) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && status.row_last) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_draw_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.draw_start |=> (state_r == ST_SETUP) && !in_ready && !out_valid)
    else $error("draw accept did not move to setup");

  a_last_row_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && status.row_last |=> in_ready && !out_valid)
    else $error("input not ready after last row");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clear_wr, cmd.load_byte, cmd.draw_start, cmd.draw_setup, cmd.row_next}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// File: hw/rtl/hflgr_datapath.sv
// Datapath: configuration registers, hex font text parser, glyph memory and row generator.
// Depends on hflgr_pkg; driven by hflgr_ctrl through command and status structs.
`default_nettype none

module hflgr_datapath
  import hflgr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire in_item_t             in_data,
  input  wire ctrl_cmd_t            cmd,
  output dp_status_t                status,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  // Configuration.
  logic [DIM_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_data;
        CFG_SCREEN_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass counter.
  logic [GLYPH_AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear_wr) begin
      clr_cnt_r <= clr_cnt_r + GLYPH_AW'(1);
    end
  end

  assign status.clear_done = (clr_cnt_r == GLYPH_AW'(GLYPH_COUNT - 1));

  // Font text parser.
  logic              data_phase_r, data_phase_nxt;
  logic [15:0]       idx_r, idx_nxt;
  logic              ovf_r, ovf_nxt;
  logic              pend_r, pend_nxt;
  logic [3:0]        high_r, high_nxt;
  logic [ROW_W:0]    grow_r, grow_nxt;
  logic              stopped_r, stopped_nxt;
  logic              store_req;
  logic [7:0]        store_val;
  logic              store_en;
  logic              restart;
  logic              row_room;
  logic              idx_ok;
  logic [3:0]        digit;
  logic [7:0]        fbyte;

  assign fbyte    = in_data.font_byte;
  assign digit    = hex_digit(fbyte);
  assign row_room = (grow_r < (ROW_W + 1)'(GLYPH_ROWS));
  assign idx_ok   = ({1'b0, idx_r} < 17'(GLYPH_COUNT));
  assign store_en = store_req && row_room && idx_ok;

  always_comb begin
    data_phase_nxt = data_phase_r;
    idx_nxt        = idx_r;
    ovf_nxt        = ovf_r;
    pend_nxt       = pend_r;
    high_nxt       = high_r;
    grow_nxt       = grow_r;
    stopped_nxt    = stopped_r;
    store_req      = 1'b0;
    store_val      = 8'd0;
    restart        = 1'b0;
    if (cmd.load_byte && !stopped_r) begin
      if (!data_phase_r) begin
        if (fbyte == CHAR_NL) begin
          restart = 1'b1;
        end else if (fbyte == CHAR_COLON) begin
          if (ovf_r) begin
            stopped_nxt = 1'b1;
          end else begin
            data_phase_nxt = 1'b1;
            pend_nxt       = 1'b0;
            grow_nxt       = '0;
          end
        end else begin
          if (idx_r[15:12] != 4'd0) ovf_nxt = 1'b1;
          idx_nxt = {idx_r[11:0], digit};
        end
      end else begin
        if (fbyte == CHAR_NL) begin
          store_req = pend_r;
          store_val = {high_r, 4'd0};
          restart   = 1'b1;
        end else if (!pend_r) begin
          high_nxt = digit;
          pend_nxt = 1'b1;
        end else begin
          store_req = 1'b1;
          store_val = {high_r, digit};
          pend_nxt  = 1'b0;
        end
      end
    end
    if (store_req && row_room) grow_nxt = grow_r + (ROW_W + 1)'(1);
    if (restart) begin
      data_phase_nxt = 1'b0;
      idx_nxt        = '0;
      ovf_nxt        = 1'b0;
      pend_nxt       = 1'b0;
      high_nxt       = '0;
      grow_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_phase_r <= 1'b0;
      idx_r        <= '0;
      ovf_r        <= 1'b0;
      pend_r       <= 1'b0;
      high_r       <= '0;
      grow_r       <= '0;
      stopped_r    <= 1'b0;
    end else begin
      data_phase_r <= data_phase_nxt;
      idx_r        <= idx_nxt;
      ovf_r        <= ovf_nxt;
      pend_r       <= pend_nxt;
      high_r       <= high_nxt;
      grow_r       <= grow_nxt;
      stopped_r    <= stopped_nxt;
    end
  end

  // Glyph memory: one word per glyph, row r in byte lane r.
  logic [ROW_BITS_W-1:0] glyph_mem [GLYPH_COUNT];
  logic [ROW_BITS_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      glyph_mem[clr_cnt_r] <= '0;
    end else if (store_en) begin
      glyph_mem[idx_r[GLYPH_AW-1:0]][grow_r[ROW_W-1:0]*8 +: 8] <= store_val;
    end
    if (cmd.draw_start) begin
      rd_data_r <= glyph_mem[in_data.codepoint[GLYPH_AW-1:0]];
    end
  end

  // Draw registers.
  logic [COORD_W-1:0] px_r, py_r;
  logic [31:0]        fg_r, bg_r;
  logic               code_ok_r;
  logic [PIX_W-1:0]   pix_r;
  logic [7:0]         colmask_r;
  logic [ROW_W-1:0]   row_r;
  logic [7:0]         colmask_nxt;
  logic [COORD_W-1:0] y_cur;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      colmask_nxt[7 - c] = (({1'b0, px_r} + DIM_W'(c)) < width_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.draw_start) begin
      px_r      <= {in_data.cell_x, 3'd0};
      py_r      <= {in_data.cell_y, 4'd0};
      fg_r      <= in_data.fg_color;
      bg_r      <= in_data.bg_color;
      code_ok_r <= ({1'b0, in_data.codepoint} < 17'(GLYPH_COUNT));
    end
    if (cmd.draw_setup) begin
      pix_r     <= PIX_W'(26'(py_r) * 26'(width_r) + 26'(px_r));
      colmask_r <= colmask_nxt;
      row_r     <= '0;
    end else if (cmd.row_next) begin
      pix_r <= pix_r + PIX_W'(width_r);
      row_r <= row_r + ROW_W'(1);
    end
  end

  assign y_cur           = {py_r[COORD_W-1:ROW_W], row_r};
  assign status.row_last = (row_r == ROW_W'(GLYPH_ROWS - 1));

  always_comb begin
    out_data              = '0;
    out_data.pixel_index  = pix_r;
    out_data.row_bits     = code_ok_r ? rd_data_r[row_r*8 +: 8] : 8'd0;
    out_data.write_mask   = ({1'b0, y_cur} < height_r) ? colmask_r : 8'd0;
    out_data.row_fg_color = fg_r;
    out_data.row_bg_color = bg_r;
    out_data.last_row     = status.row_last;
  end

endmodule

`default_nettype wire

// File: hw/rtl/hex_font_loader_glyph_renderer.sv
// Top level of the hex font loader and 8x16 glyph renderer.
// Instantiates hflgr_ctrl and hflgr_datapath; uses hflgr_pkg types.
//
//   Channel  Ports                               Moves
//   input    in_valid / in_ready / in_data       one load byte or one draw item
//   result   out_valid / out_ready / out_data    one glyph row result
//   config   cfg_we / cfg_index / cfg_data       screen width (0) or height (1)
//
// After reset a clearing pass zeroes the glyph memory, one glyph per cycle;
// no item is accepted until it finishes, though configuration writes are
// taken throughout.
// For a load item the parser updates and the memory byte is written in the
// accept cycle.
// For a draw item the accept cycle reads the glyph word, the setup state forms
// the base pixel index (one multiply) and column mask, then the emit state gives
// one row result per cycle while out_ready is high, for 16 rows.
// The renderer handles one item at a time; out_ready low holds the current row
// and the input stays not ready until the sixteenth row is taken.
`default_nettype none

module hex_font_loader_glyph_renderer
  import hflgr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DIM_W-1:0]     cfg_data
);

  // Commands from the controller and status back from the datapath.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  hflgr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  hflgr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

`default_nettype wire

// File: test/tb_hex_font_loader_glyph_renderer.sv
// Self-checking testbench for hex_font_loader_glyph_renderer.
// Feeds hex-font text and draw items, predicts every glyph row result in the
// testbench and compares. Depends on hflgr_pkg and the top-level RTL.
`timescale 1ns / 1ps

module tb_hex_font_loader_glyph_renderer;
  import hflgr_pkg::*;

  // The limit covers the clearing pass after reset as well. The rest of
  // the run stays far below this limit even with heavy stalls on both sides.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // This many idle cycles after the last expected row are enough for the
  // block to settle before a register write.
  localparam int unsigned SETTLE_TICKS = 24;
  localparam int unsigned POOL_SIZE    = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;

  // Knobs shared between the stimulus tasks and the receiver process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_left  = 0;

  int unsigned items_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Glyph rows that the block must still deliver, oldest first.
  out_item_t expected_rows[$];

  // Code points that the random part both loads and draws, so that most
  // draws show glyphs with real content.
  logic [15:0] glyph_pool [0:POOL_SIZE-1];

  // Shadow of the block: screen geometry, glyph memory and the font parser.
  logic [DIM_W-1:0] scr_w = WIDTH_RESET;
  logic [DIM_W-1:0] scr_h = HEIGHT_RESET;
  bit [7:0]  glyph_mem [0:GLYPH_COUNT*GLYPH_ROWS-1];
  bit        in_rows;          // past the ':' of the current line
  bit [15:0] idx_acc;
  bit        idx_too_big;
  bit        half_byte_valid;
  bit [3:0]  half_byte;
  bit [4:0]  row_cnt;
  bit        font_locked;      // an oversized index stops loading for good

  hex_font_loader_glyph_renderer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Font parser and renderer shadow
  // ---------------------------------------------------------------------

  // Anything that is not a hex digit reads as zero.
  function automatic logic [3:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'd0;
  endfunction

  function automatic void line_restart();
    in_rows         = 1'b0;
    idx_acc         = '0;
    idx_too_big     = 1'b0;
    half_byte_valid = 1'b0;
    half_byte       = '0;
    row_cnt         = '0;
  endfunction

  // Rows past the sixteenth of a line are parsed but thrown away; the row
  // counter sticks at the glyph height.
  function automatic void put_row(input logic [7:0] v);
    if (row_cnt < GLYPH_ROWS) begin
      glyph_mem[{idx_acc, row_cnt[3:0]}] = v;
      row_cnt++;
    end
  endfunction

  function automatic void font_parse(input logic [7:0] c);
    if (font_locked) return;
    if (!in_rows) begin
      if (c == CHAR_NL) begin
        // A newline before the ':' throws the partial index away.
        line_restart();
      end else if (c == CHAR_COLON) begin
        if (idx_too_big) begin
          font_locked = 1'b1;
        end else begin
          in_rows         = 1'b1;
          half_byte_valid = 1'b0;
          row_cnt         = '0;
        end
      end else begin
        if (idx_acc[15:12] != 4'd0) idx_too_big = 1'b1;
        idx_acc = {idx_acc[11:0], digit_value(c)};
      end
    end else if (c == CHAR_NL) begin
      // A lone high nibble at the end of the line becomes a full row.
      if (half_byte_valid) put_row({half_byte, 4'h0});
      line_restart();
    end else if (!half_byte_valid) begin
      half_byte       = digit_value(c);
      half_byte_valid = 1'b1;
    end else begin
      put_row({half_byte, digit_value(c)});
      half_byte_valid = 1'b0;
    end
  endfunction

  // Sixteen rows per draw: framebuffer index of the left pixel, glyph bits,
  // and a mask of the pixels that fall inside the screen.
  function automatic void draw_rows(input in_item_t it);
    out_item_t   r;
    int unsigned px, py, y;
    logic [63:0] lin;
    px = 32'(it.cell_x) * 8;
    py = 32'(it.cell_y) * 16;
    for (int row = 0; row < GLYPH_ROWS; row++) begin
      y   = py + row;
      lin = 64'(y) * 64'(scr_w) + 64'(px);
      r.pixel_index = lin[PIX_W-1:0];
      r.row_bits    = glyph_mem[{it.codepoint, 4'(row)}];
      r.write_mask  = '0;
      for (int col = 0; col < 8; col++) begin
        if (y < scr_h && px + col < scr_w) r.write_mask[7-col] = 1'b1;
      end
      r.row_fg_color = it.fg_color;
      r.row_bg_color = it.bg_color;
      r.last_row     = (row == GLYPH_ROWS - 1);
      expected_rows.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random ready, long hold-offs, and the row checker
  // ---------------------------------------------------------------------

  // A hold-off request from a test keeps ready low until its count runs out,
  // which fills the block and stalls its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_left != 0) begin
      out_ready     <= 1'b0;
      hold_off_left <= hold_off_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row result: idx=%h bits=%h mask=%h fg=%h bg=%h last=%b",
                   out_data.pixel_index, out_data.row_bits, out_data.write_mask,
                   out_data.row_fg_color, out_data.row_bg_color, out_data.last_row);
      end else begin
        want = expected_rows.pop_front();
        if (out_data.pixel_index  !== want.pixel_index  ||
            out_data.row_bits     !== want.row_bits     ||
            out_data.write_mask   !== want.write_mask   ||
            out_data.row_fg_color !== want.row_fg_color ||
            out_data.row_bg_color !== want.row_bg_color ||
            out_data.last_row     !== want.last_row) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("row mismatch at cycle %0d", cycle_count);
            $display("  expected idx=%h bits=%h mask=%h fg=%h bg=%h last=%b",
                     want.pixel_index, want.row_bits, want.write_mask,
                     want.row_fg_color, want.row_bg_color, want.last_row);
            $display("  actual   idx=%h bits=%h mask=%h fg=%h bg=%h last=%b",
                     out_data.pixel_index, out_data.row_bits, out_data.write_mask,
                     out_data.row_fg_color, out_data.row_bg_color, out_data.last_row);
          end
        end
      end
    end
  end

  // A hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d rows outstanding", expected_rows.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Every field gets random filler, so fields that an item does not use
  // still see both values on every bit.
  function automatic in_item_t random_item();
    in_item_t it;
    it.command   = 1'($urandom);
    it.font_byte = 8'($urandom);
    it.cell_x    = 9'($urandom);
    it.cell_y    = 8'($urandom);
    it.codepoint = 16'($urandom);
    it.fg_color  = $urandom;
    it.bg_color  = $urandom;
    return it;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return 8'(n) - 8'd10 + (upper ? 8'h41 : 8'h61);
  endfunction

  // Cell index one below, at or one above the screen border, kept in range.
  function automatic int unsigned near_border(input int unsigned border_cell,
                                              input int unsigned max_cell);
    int unsigned v;
    v = border_cell + $urandom_range(0, 2);
    v = (v == 0) ? 0 : v - 1;
    return (v > max_cell) ? max_cell : v;
  endfunction

  // Offers one item and holds it until accepted, then updates the shadow.
  // Valid stays high into the next item unless an idle gap is drawn.
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (it.command == CMD_DRAW) draw_rows(it);
    else font_parse(it.font_byte);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic send_load(input logic [7:0] c);
    in_item_t it;
    it           = random_item();
    it.command   = CMD_LOAD;
    it.font_byte = c;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_load(s[i]);
  endtask

  task automatic send_draw(input logic [15:0] code, input logic [8:0] cx,
                           input logic [7:0] cy, input logic [31:0] fg,
                           input logic [31:0] bg);
    in_item_t it;
    it           = random_item();
    it.command   = CMD_DRAW;
    it.codepoint = code;
    it.cell_x    = cx;
    it.cell_y    = cy;
    it.fg_color  = fg;
    it.bg_color  = bg;
    send_item(it);
  endtask

  // Draw with random colors; half the cells sit on the screen border.
  task automatic send_random_draw(input logic [15:0] code);
    logic [8:0] cx;
    logic [7:0] cy;
    if ($urandom_range(0, 1) == 0) begin
      cx = 9'($urandom);
      cy = 8'($urandom);
    end else begin
      cx = 9'(near_border(scr_w >> 3, 511));
      cy = 8'(near_border(scr_h >> 4, 255));
    end
    send_draw(code, cx, cy, $urandom, $urandom);
  endtask

  function automatic logic [15:0] pool_code();
    return glyph_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Index digits with optional leading zeros and random letter case.
  task automatic send_index(input logic [15:0] code);
    int unsigned ndig;
    ndig = (code[15:12] != 0) ? 4 : (code[11:8] != 0) ? 3 : (code[7:4] != 0) ? 2 : 1;
    ndig = $urandom_range(ndig, 4);
    for (int i = int'(ndig) - 1; i >= 0; i--)
      send_load(hex_char(4'(code >> (4 * i)), 1'($urandom)));
  endtask

  // One complete line. Most carry a few rows, some run past sixteen rows,
  // and some end on a lone high nibble.
  task automatic send_font_line(input logic [15:0] code);
    int unsigned nrows;
    if (in_rows || idx_acc != 0 || idx_too_big) send_load(CHAR_NL);
    send_index(code);
    send_load(CHAR_COLON);
    nrows = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
    for (int unsigned i = 0; i < 2 * nrows + $urandom_range(0, 1); i++)
      send_load(hex_char(4'($urandom), 1'($urandom)));
    send_load(CHAR_NL);
  endtask

  // A line cut short with a draw of the same glyph in the middle of it.
  task automatic send_broken_line(input logic [15:0] code);
    if (in_rows || idx_acc != 0 || idx_too_big) send_load(CHAR_NL);
    send_index(code);
    send_load(CHAR_COLON);
    repeat ($urandom_range(1, 5)) send_load(hex_char(4'($urandom), 1'($urandom)));
    send_random_draw(code);
  endtask

  // Random bytes; a ':' that would end loading for good is turned into a
  // newline, since that case is kept for the end of the run.
  task automatic send_noise();
    logic [7:0] c;
    c = 8'($urandom);
    if (c == CHAR_COLON && !in_rows && idx_too_big) c = CHAR_NL;
    send_load(c);
  endtask

  // Stops offering, waits for every expected row, then lets the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Only called with the block idle; the shadow follows at once.
  task automatic write_screen(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Blank glyphs with the reset geometry of 640 by 480: the origin cell, the
  // last cell on screen, the first cell past both borders, and the far corner.
  task automatic test_reset_geometry();
    send_draw(16'h0000, 9'd0,   8'd0,   32'h0000_0000, 32'hFFFF_FFFF);
    send_draw(16'hFFFF, 9'd79,  8'd29,  32'hFFFF_FFFF, 32'h0000_0000);
    send_draw(16'h1234, 9'd80,  8'd30,  32'h5A5A_A5A5, 32'hA5A5_5A5A);
    send_draw(16'h00FF, 9'd511, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Font text syntax. A junk index character reads as zero and a newline
  // drops the partial index; a ':' among the rows reads as zero as well;
  // mixed-case hex loads the top glyph; a mid-line draw sees only the rows
  // finished so far, and the closing newline adds the odd trailing nibble.
  task automatic test_font_syntax();
    send_text("x5\n2:b:\n");
    send_text("ffFF:9A7");
    send_draw(16'hFFFF, 9'd1, 8'd1, 32'h0000_0000, 32'hFFFF_FFFF);
    send_load(CHAR_NL);
    send_draw(16'hFFFF, 9'd2, 8'd2, 32'hFFFF_FFFF, 32'h0000_0000);
    send_draw(16'h0002, 9'd3, 8'd3, 32'h1234_5678, 32'h8765_4321);
  endtask

  // Geometry extremes: a single pixel, the full 4096 square, and a border
  // that cuts a cell in the middle both across and down.
  task automatic test_screen_extremes();
    wait_drained();
    write_screen(13'd1, 13'd1);
    send_draw(16'hFFFF, 9'd0,   8'd0,   $urandom, $urandom);
    send_draw(16'h0002, 9'd511, 8'd255, $urandom, $urandom);
    wait_drained();
    write_screen(13'd4096, 13'd4096);
    send_draw(16'hFFFF, 9'd511, 8'd255, $urandom, $urandom);
    send_draw(16'h0002, 9'd0,   8'd0,   $urandom, $urandom);
    wait_drained();
    write_screen(13'd643, 13'd37);
    send_draw(16'hFFFF, 9'd80, 8'd2, $urandom, $urandom);
    send_draw(16'h0002, 9'd79, 8'd1, $urandom, $urandom);
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while draws keep coming, so
  // the block fills and stops taking items.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left <= 300;
    repeat (4) send_random_draw(pool_code());
    wait_drained();
  endtask

  // Mostly well-formed font lines and draws, with noise and cut lines mixed in.
  task automatic test_random_traffic(input int unsigned n, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned stop_at, pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = items_sent + n;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) send_font_line(pool_code());
      else if (pick < 75) send_random_draw(($urandom_range(0, 3) != 0) ? pool_code()
                                                                       : 16'($urandom));
      else if (pick < 90) send_noise();
      else send_broken_line(pool_code());
    end
    wait_drained();
  endtask

  // An index of five digits overflows; its ':' stops all loading, so the
  // line after it leaves the glyphs as they were.
  task automatic test_stop_loading();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text("\n10000:1:FF\n2:00\n");
    send_draw(16'h0001, 9'd4, 8'd4, $urandom, $urandom);
    send_draw(16'h0002, 9'd5, 8'd5, $urandom, $urandom);
    wait_drained();
  endtask

  initial begin
    foreach (glyph_pool[i]) glyph_pool[i] = 16'($urandom);
    glyph_pool[0] = 16'h0000;
    glyph_pool[1] = 16'hFFFF;
    glyph_pool[2] = 16'h0002;
    glyph_pool[3] = 16'h0001;

    // Synchronous reset at the start; the block then clears its glyph
    // memory before it takes the first item.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_font_syntax();
    test_screen_extremes();
    test_backpressure();

    write_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    test_random_traffic(50, 0, 0);
    write_screen(13'($urandom_range(1, 700)), 13'($urandom_range(1, 500)));
    test_random_traffic(50, 79, 0);
    write_screen(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
    test_random_traffic(50, 0, 79);
    write_screen(WIDTH_RESET, HEIGHT_RESET);
    test_random_traffic(50, 8, 8);

    test_stop_loading();

    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
